@@ design/phf_pkg.sv @@
// Package for the PUS packet HDLC framer: field widths, line and header codes,
// item and job types. Used by every module of the block and by the testbench.
// Depends on nothing.
`default_nettype none

package phf_pkg;

    localparam int unsigned APP_ID_W = 11;
    localparam int unsigned SEQ_W    = 14;
    localparam int unsigned DLEN_W   = 12;
    localparam int unsigned PLEN_W   = 16;
    localparam int unsigned PLEN_EXT = PLEN_W + 1;

    localparam int unsigned NUM_COUNTERS_DEF = 8;
    localparam int unsigned MAX_DATA_LEN_DEF = 2048;

    localparam logic [APP_ID_W-1:0] SYS_ID_RESET = 11'd1;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_FLAG  = 8'h5E;
    localparam logic [7:0] ESC_ESC   = 8'h5D;
    localparam logic [7:0] PAD_BYTE  = 8'h00;
    localparam logic [1:0] SEQ_UNSEG = 2'b11;
    localparam logic [3:0] SEC_HDR   = 4'h1;
    localparam logic [PLEN_W-1:0] PLEN_OFFSET = 16'd5;

    localparam int unsigned HDR_BYTES = 10;
    localparam int unsigned JOB_SYMS  = 14;
    localparam int unsigned CNT_W     = $clog2(JOB_SYMS + 1);

    localparam logic CMD_HEADER = 1'b0;
    localparam logic CMD_DATA   = 1'b1;
    localparam logic PKT_TM     = 1'b0;
    localparam logic PKT_TC     = 1'b1;

    typedef struct packed {
        logic                command;
        logic                pkt_type;
        logic [APP_ID_W-1:0] app_id;
        logic [7:0]          dest_id;
        logic [3:0]          ack;
        logic [7:0]          service_type;
        logic [7:0]          service_subtype;
        logic [SEQ_W-1:0]    seq_count_in;
        logic [DLEN_W-1:0]   data_len;
        logic [7:0]          data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } t_out_item;

    typedef logic [APP_ID_W-1:0] t_cfg_word;

    // One frame byte before stuffing: escape it or not, closing flag or not.
    typedef struct packed {
        logic [7:0] val;
        logic       stuff;
        logic       fend;
    } t_sym;

    typedef struct packed {
        t_sym [JOB_SYMS-1:0] sym;
        logic [CNT_W-1:0]    cnt;
    } t_job;

    function automatic t_sym mk_sym(input logic [7:0] val, input logic stuff,
                                    input logic fend);
        t_sym s;
        s.val   = val;
        s.stuff = stuff;
        s.fend  = fend;
        return s;
    endfunction

endpackage

`default_nettype wire

@@ design/phf_stream_if.sv @@
// Valid/ready channel used for the input items, the results and the
// configuration writes. The payload type is a parameter; depends on nothing.
`default_nettype none

interface phf_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/phf_builder.sv @@
// Input register, sequence counters and frame state; turns each accepted header,
// and each data item of an open frame, into a job of unstuffed frame bytes held in a job register. Depends on phf_pkg.
`default_nettype none

module phf_builder #(
    parameter int unsigned NUM_COUNTERS = phf_pkg::NUM_COUNTERS_DEF,
    parameter int unsigned MAX_DATA_LEN = phf_pkg::MAX_DATA_LEN_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    phf_stream_if.sink         i_in,
    phf_stream_if.sink         i_cfg,
    output phf_pkg::t_job      o_job,
    output logic               o_job_valid,
    input  wire logic          i_job_take
);
    import phf_pkg::*;

    localparam int unsigned IDX_W       = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
    localparam int unsigned LEN_W       = $clog2(MAX_DATA_LEN + 1);
    localparam int unsigned RECIP_SHIFT = 20;
    localparam int unsigned RECIP       = ((1 << RECIP_SHIFT) + NUM_COUNTERS - 1)
                                          / NUM_COUNTERS;
    localparam int unsigned QN_W        = 20;

    logic [APP_ID_W-1:0] r_sys_id;
    logic                r_a_valid;
    t_in_item            r_a;
    logic [APP_ID_W-1:0] r_a_q;
    logic [7:0]          r_ctr [0:NUM_COUNTERS-1];
    logic [LEN_W-1:0]    r_rem;
    logic [7:0]          r_xor;
    logic                r_open;
    logic                r_job_valid;
    t_job                r_job;

    logic                a_adv;
    logic                in_acc;
    logic [APP_ID_W-1:0] key_in;
    logic [31:0]         prod_in;
    logic [APP_ID_W-1:0] key;
    logic [QN_W-1:0]     qn;
    logic [APP_ID_W-1:0] rem;
    logic [IDX_W-1:0]    idx;
    logic                use_cnt;
    logic [7:0]          ctr_cur;
    logic [SEQ_W-1:0]    seq;
    logic [PLEN_EXT-1:0] dlen_x;
    logic [PLEN_EXT-1:0] dlen_sat_x;
    logic [LEN_W-1:0]    dlen_sat;
    logic [PLEN_W-1:0]   plen;
    logic [7:0]          hdr [0:HDR_BYTES-1];
    logic [7:0]          hx;
    logic [7:0]          dx;
    logic                is_hdr;
    logic                job_gen;
    t_job                job;

    // Stage A: the counter index is key mod NUM_COUNTERS; the quotient comes
    // from a reciprocal multiply, exact for 11-bit keys.
    assign a_adv      = r_a_valid && (!r_job_valid || i_job_take);
    assign i_in.ready = !r_a_valid || a_adv;
    assign in_acc     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign key_in  = (i_in.data.pkt_type == PKT_TC) ? i_in.data.app_id
                                                     : APP_ID_W'(i_in.data.dest_id);
    assign prod_in = 32'(key_in) * 32'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_sys_id  <= SYS_ID_RESET;
        end else begin
            if (i_cfg.valid) begin
                r_sys_id <= i_cfg.data;
            end
            if (in_acc) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a   <= i_in.data;
            r_a_q <= prod_in[RECIP_SHIFT +: APP_ID_W];
        end
    end

    // Stage B: header fields, counter update and job assembly.
    assign is_hdr  = (r_a.command == CMD_HEADER);
    assign key     = (r_a.pkt_type == PKT_TC) ? r_a.app_id : APP_ID_W'(r_a.dest_id);
    assign qn      = QN_W'(r_a_q) * QN_W'(NUM_COUNTERS);
    assign rem     = key - qn[APP_ID_W-1:0];
    assign idx     = rem[IDX_W-1:0];
    assign ctr_cur = r_ctr[idx];
    assign use_cnt = ((r_a.pkt_type == PKT_TC) && (APP_ID_W'(r_a.dest_id) == r_sys_id))
                  || ((r_a.pkt_type == PKT_TM) && (r_a.app_id == r_sys_id));
    assign seq     = use_cnt ? SEQ_W'(ctr_cur) : r_a.seq_count_in;

    assign dlen_x     = PLEN_EXT'(r_a.data_len);
    assign dlen_sat_x = (dlen_x > PLEN_EXT'(MAX_DATA_LEN)) ? PLEN_EXT'(MAX_DATA_LEN) : dlen_x;
    assign dlen_sat   = dlen_sat_x[LEN_W-1:0];
    assign plen       = dlen_sat_x[PLEN_W-1:0] + PLEN_OFFSET;

    assign hdr[0] = {3'b000, r_a.pkt_type, 1'b1, r_a.app_id[10:8]};
    assign hdr[1] = r_a.app_id[7:0];
    assign hdr[2] = {SEQ_UNSEG, seq[13:8]};
    assign hdr[3] = seq[7:0];
    assign hdr[4] = plen[15:8];
    assign hdr[5] = plen[7:0];
    assign hdr[6] = (r_a.pkt_type == PKT_TC) ? {SEC_HDR, r_a.ack} : {SEC_HDR, 4'h0};
    assign hdr[7] = r_a.service_type;
    assign hdr[8] = r_a.service_subtype;
    assign hdr[9] = r_a.dest_id;

    always_comb begin
        hx = 8'h00;
        for (int i = 0; i < HDR_BYTES; i++) begin
            hx = hx ^ hdr[i];
        end
    end

    assign dx      = r_xor ^ r_a.data_byte;
    assign job_gen = is_hdr || r_open;

    always_comb begin
        job.sym = '0;
        job.cnt = '0;
        if (is_hdr) begin
            job.sym[0] = mk_sym(FLAG_BYTE, 1'b0, 1'b0);
            for (int i = 0; i < HDR_BYTES; i++) begin
                job.sym[i + 1] = mk_sym(hdr[i], 1'b1, 1'b0);
            end
            if (dlen_sat == '0) begin
                job.sym[HDR_BYTES + 1] = mk_sym(PAD_BYTE, 1'b1, 1'b0);
                job.sym[HDR_BYTES + 2] = mk_sym(hx, 1'b1, 1'b0);
                job.sym[HDR_BYTES + 3] = mk_sym(FLAG_BYTE, 1'b0, 1'b1);
                job.cnt = CNT_W'(HDR_BYTES + 4);
            end else begin
                job.cnt = CNT_W'(HDR_BYTES + 1);
            end
        end else begin
            job.sym[0] = mk_sym(r_a.data_byte, 1'b1, 1'b0);
            if (r_rem == LEN_W'(1)) begin
                job.sym[1] = mk_sym(PAD_BYTE, 1'b1, 1'b0);
                job.sym[2] = mk_sym(dx, 1'b1, 1'b0);
                job.sym[3] = mk_sym(FLAG_BYTE, 1'b0, 1'b1);
                job.cnt    = CNT_W'(4);
            end else begin
                job.cnt = CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COUNTERS; i++) begin
                r_ctr[i] <= 8'h00;
            end
            r_rem       <= '0;
            r_xor       <= 8'h00;
            r_open      <= 1'b0;
            r_job_valid <= 1'b0;
        end else begin
            if (a_adv && job_gen) begin
                r_job_valid <= 1'b1;
            end else if (i_job_take) begin
                r_job_valid <= 1'b0;
            end
            if (a_adv) begin
                if (is_hdr) begin
                    if (use_cnt) begin
                        r_ctr[idx] <= ctr_cur + 8'd1;
                    end
                    r_rem  <= dlen_sat;
                    r_open <= (dlen_sat != '0);
                    r_xor  <= (dlen_sat != '0) ? hx : 8'h00;
                end else if (r_open) begin
                    if (r_rem == LEN_W'(1)) begin
                        r_rem  <= '0;
                        r_open <= 1'b0;
                        r_xor  <= 8'h00;
                    end else begin
                        r_rem <= r_rem - LEN_W'(1);
                        r_xor <= dx;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv && job_gen) begin
            r_job <= job;
        end
    end

    assign o_job       = r_job;
    assign o_job_valid = r_job_valid;

endmodule

`default_nettype wire

@@ design/phf_stuffer.sv @@
// Byte stuffer: shifts the symbols of one job out one line byte per cycle unless
// stalled, escaping flag and escape bytes, into the output register. Depends on phf_pkg.
`default_nettype none

module phf_stuffer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire phf_pkg::t_job i_job,
    input  wire logic          i_job_valid,
    output logic               o_job_take,
    phf_stream_if.source       o_out
);
    import phf_pkg::*;

    t_sym [JOB_SYMS-1:0] r_sym;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_esc;
    logic                r_ov;
    t_out_item           r_out;

    logic      out_free;
    logic      step;
    logic      special;
    logic      consume;
    logic      fin;
    logic      load;
    t_out_item emit;

    assign out_free = !r_ov || o_out.ready;
    assign step     = out_free && (r_cnt != '0);
    assign special  = r_sym[0].stuff
                   && ((r_sym[0].val == FLAG_BYTE) || (r_sym[0].val == ESC_BYTE));
    assign consume  = r_esc || !special;
    assign fin      = consume && (r_cnt == CNT_W'(1));
    assign load     = i_job_valid && ((r_cnt == '0) || (step && fin));
    assign o_job_take = load;

    always_comb begin
        if (r_esc) begin
            emit.out_byte = (r_sym[0].val == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
        end else if (special) begin
            emit.out_byte = ESC_BYTE;
        end else begin
            emit.out_byte = r_sym[0].val;
        end
        emit.run_last  = fin;
        emit.frame_end = consume && r_sym[0].fend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_esc <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (load) begin
                r_cnt <= i_job.cnt;
                r_esc <= 1'b0;
            end else if (step) begin
                if (consume) begin
                    r_cnt <= r_cnt - CNT_W'(1);
                    r_esc <= 1'b0;
                end else begin
                    r_esc <= 1'b1;
                end
            end
            if (step) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sym <= i_job.sym;
        end else if (step && consume) begin
            for (int i = 0; i < JOB_SYMS - 1; i++) begin
                r_sym[i] <= r_sym[i + 1];
            end
            r_sym[JOB_SYMS-1] <= '0;
        end
        if (step) begin
            r_out <= emit;
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    a_esc_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc |-> (r_cnt != '0) && special)
        else $error("escape pending without an escapable symbol");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.frame_end) |-> (r_out.run_last && (r_out.out_byte == FLAG_BYTE)))
        else $error("closing flag not marked as last byte of its transfer");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(JOB_SYMS))
        else $error("symbol count out of range");

    a_load_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && (r_cnt != '0)) |-> (step && fin))
        else $error("job loaded over unsent symbols");

endmodule

`default_nettype wire

@@ design/pus_packet_hdlc_framer_unit.sv @@
// Top level of the PUS packet HDLC framer: builder stage followed by the byte
// stuffer. Depends on phf_pkg, phf_stream_if, phf_builder and phf_stuffer.
//
// A header transfer opens a frame and produces the start flag and ten header
// bytes (plus pad, checksum and end flag when the data length is zero); each
// following data transfer produces its byte, and the last one also closes the
// frame. The output side emits one line byte per cycle while the receiver is
// ready. A data byte causes one or two line bytes (four to six for the last
// one), a header eleven to twenty-one (fourteen to twenty-five when the data
// length is zero). The stuffer's one-byte-per-cycle shift register sets the
// pace; the input register and job register ahead of it let the next item be
// taken while the current one is still being sent. An item passes through the
// input register, job register, stuffer symbol register and output register. The
// configuration register should be written only while no item is in flight.
`default_nettype none

module pus_packet_hdlc_framer_unit #(
    parameter int unsigned NUM_COUNTERS = phf_pkg::NUM_COUNTERS_DEF,
    parameter int unsigned MAX_DATA_LEN = phf_pkg::MAX_DATA_LEN_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    phf_stream_if.sink   i_in,
    phf_stream_if.sink   i_cfg,
    phf_stream_if.source o_out
);
    import phf_pkg::*;

    t_job job;
    logic job_valid;
    logic job_take;

    phf_builder #(
        .NUM_COUNTERS (NUM_COUNTERS),
        .MAX_DATA_LEN (MAX_DATA_LEN)
    ) u_builder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (i_cfg),
        .o_job       (job),
        .o_job_valid (job_valid),
        .i_job_take  (job_take)
    );

    phf_stuffer u_stuffer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .i_job_valid (job_valid),
        .o_job_take  (job_take),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

@@ sim/pus_packet_hdlc_framer_unit_tb.sv @@
// Testbench for pus_packet_hdlc_framer_unit: directed and random packets, checked byte by byte
// against an in-bench frame predictor or hand-typed bytes. Depends on phf_pkg, phf_stream_if and the framer RTL.
`timescale 1ns / 1ps

module pus_packet_hdlc_framer_unit_tb;
    import phf_pkg::*;

    localparam int PREDICTED      = -1;
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int TIMEOUT_NS     = 3_000_000;
    localparam int PHASES         = 6;
    localparam int NODE_LOW_RAND  = -1;
    localparam int NODE_HIGH_RAND = -2;

    typedef struct {
        t_in_item   item;
        int         typed_n;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    phf_stream_if #(.T(t_in_item))  in_if ();
    phf_stream_if #(.T(t_cfg_word)) cfg_if ();
    phf_stream_if #(.T(t_out_item)) out_if ();

    pus_packet_hdlc_framer_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // Predictor state.
    t_cfg_word         node_id;
    logic [7:0]        seq_ctr [NUM_COUNTERS_DEF];
    logic [DLEN_W-1:0] bytes_left;
    logic [7:0]        frame_xor;
    logic              in_frame;
    t_out_item         step_out [$];
    t_out_item         line_q [$];

    int fail_cnt = 0;
    int items_sent = 0;
    int hold_asks = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;

    int ph_node   [PHASES] = '{2047, 0, NODE_LOW_RAND, NODE_HIGH_RAND, NODE_LOW_RAND, 255};
    int ph_tx     [PHASES] = '{0, 0, 52, 0, 9, 0};
    int ph_rx     [PHASES] = '{0, 0, 0, 52, 9, 0};
    int ph_items  [PHASES] = '{258, 8, 8, 8, 8, 8};
    bit ph_wrap   [PHASES] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    bit ph_press  [PHASES] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void line_put(input logic [7:0] b, input logic fe);
        t_out_item o;
        o.out_byte  = b;
        o.run_last  = 1'b0;
        o.frame_end = fe;
        step_out.push_back(o);
    endfunction

    function automatic void line_put_stuffed(input logic [7:0] b);
        if (b == FLAG_BYTE) begin
            line_put(ESC_BYTE, 1'b0);
            line_put(ESC_FLAG, 1'b0);
        end else if (b == ESC_BYTE) begin
            line_put(ESC_BYTE, 1'b0);
            line_put(ESC_ESC, 1'b0);
        end else begin
            line_put(b, 1'b0);
        end
    endfunction

    function automatic void frame_close();
        line_put_stuffed(PAD_BYTE);
        line_put_stuffed(frame_xor);
        line_put(FLAG_BYTE, 1'b1);
        in_frame   = 1'b0;
        bytes_left = '0;
        frame_xor  = '0;
    endfunction

    function automatic void frame_predict(input t_in_item it);
        logic [HDR_BYTES-1:0][7:0] hdr;
        logic [DLEN_W-1:0]         dlen;
        logic [SEQ_W-1:0]          seq;
        logic [PLEN_W-1:0]         plen;
        int                        k;
        step_out.delete();
        if (it.command == CMD_HEADER) begin
            dlen = (it.data_len > MAX_DATA_LEN_DEF) ? DLEN_W'(MAX_DATA_LEN_DEF) : it.data_len;
            seq = it.seq_count_in;
            if (it.pkt_type == PKT_TC && APP_ID_W'(it.dest_id) == node_id) begin
                k = it.app_id % NUM_COUNTERS_DEF;
                seq = SEQ_W'(seq_ctr[k]);
                seq_ctr[k] = seq_ctr[k] + 8'd1;
            end else if (it.pkt_type == PKT_TM && it.app_id == node_id) begin
                k = it.dest_id % NUM_COUNTERS_DEF;
                seq = SEQ_W'(seq_ctr[k]);
                seq_ctr[k] = seq_ctr[k] + 8'd1;
            end
            plen = PLEN_W'(dlen) + PLEN_OFFSET;
            hdr[0] = {3'b000, it.pkt_type, 1'b1, it.app_id[10:8]};
            hdr[1] = it.app_id[7:0];
            hdr[2] = {SEQ_UNSEG, seq[13:8]};
            hdr[3] = seq[7:0];
            hdr[4] = plen[15:8];
            hdr[5] = plen[7:0];
            hdr[6] = {SEC_HDR, (it.pkt_type == PKT_TC) ? it.ack : 4'h0};
            hdr[7] = it.service_type;
            hdr[8] = it.service_subtype;
            hdr[9] = it.dest_id;
            frame_xor = '0;
            line_put(FLAG_BYTE, 1'b0);
            for (int i = 0; i < HDR_BYTES; i++) begin
                frame_xor = frame_xor ^ hdr[i];
                line_put_stuffed(hdr[i]);
            end
            in_frame   = 1'b1;
            bytes_left = dlen;
            if (dlen == 0) frame_close();
        end else if (in_frame) begin
            frame_xor = frame_xor ^ it.data_byte;
            line_put_stuffed(it.data_byte);
            bytes_left = bytes_left - 1'b1;
            if (bytes_left == 0) frame_close();
        end
        if (step_out.size() > 0) step_out[step_out.size() - 1].run_last = 1'b1;
    endfunction

    function automatic logic [7:0] rand_line_byte();
        case ($urandom_range(9))
            0: return FLAG_BYTE;
            1: return ESC_BYTE;
            default: return 8'($urandom());
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.command         = 1'($urandom_range(1));
        it.pkt_type        = 1'($urandom_range(1));
        it.app_id          = APP_ID_W'($urandom());
        it.dest_id         = 8'($urandom());
        it.ack             = 4'($urandom());
        it.service_type    = 8'($urandom());
        it.service_subtype = 8'($urandom());
        it.seq_count_in    = SEQ_W'($urandom());
        it.data_len        = DLEN_W'($urandom());
        it.data_byte       = 8'($urandom());
        return it;
    endfunction

    function automatic t_in_item mk_data(input logic [7:0] b);
        t_in_item it;
        it = rand_item();
        it.command   = CMD_DATA;
        it.data_byte = b;
        return it;
    endfunction

    function automatic t_in_item mk_hdr(input logic typ, input logic [APP_ID_W-1:0] app,
                                        input logic [7:0] dest, input logic [3:0] ack,
                                        input logic [7:0] st, input logic [7:0] ss,
                                        input logic [SEQ_W-1:0] seq,
                                        input logic [DLEN_W-1:0] dlen);
        t_in_item it;
        it = rand_item();
        it.command         = CMD_HEADER;
        it.pkt_type        = typ;
        it.app_id          = app;
        it.dest_id         = dest;
        it.ack             = ack;
        it.service_type    = st;
        it.service_subtype = ss;
        it.seq_count_in    = seq;
        it.data_len        = dlen;
        return it;
    endfunction

    function automatic t_row mk_row(input t_in_item it, input int n, input logic [7:0] b0,
                                    input logic [7:0] b1);
        t_row r;
        r.item    = it;
        r.typed_n = n;
        r.b0      = b0;
        r.b1      = b1;
        return r;
    endfunction

    task automatic send_item(input t_in_item it, input int typed_n, input logic [7:0] b0,
                             input logic [7:0] b1);
        t_out_item o;
        logic      counts;
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        counts = (it.command == CMD_HEADER) || in_frame;
        frame_predict(it);
        if (typed_n == PREDICTED) begin
            foreach (step_out[i]) line_q.push_back(step_out[i]);
        end else begin
            for (int i = 0; i < typed_n; i++) begin
                o.out_byte  = (i == 0) ? b0 : b1;
                o.run_last  = (i == typed_n - 1);
                o.frame_end = 1'b0;
                line_q.push_back(o);
            end
        end
        if (counts) items_sent++;
        @(negedge i_clk);
    endtask

    task automatic random_frame();
        t_in_item h;
        int       n_body;
        int       n_sent;
        int       r;
        if (!in_frame && $urandom_range(99) < 6) begin
            send_item(mk_data(rand_line_byte()), PREDICTED, 8'h00, 8'h00);
        end else begin
            h = rand_item();
            h.command = CMD_HEADER;
            if (h.pkt_type == PKT_TM && $urandom_range(99) < 40) h.app_id = node_id;
            if (h.pkt_type == PKT_TC && node_id < 256 && $urandom_range(99) < 40) begin
                h.dest_id = node_id[7:0];
            end
            h.service_type    = rand_line_byte();
            h.service_subtype = rand_line_byte();
            r = $urandom_range(99);
            if (r < 5) begin
                h.data_len = DLEN_W'($urandom_range(4095, 2048));
            end else if (r < 15) begin
                h.data_len = DLEN_W'($urandom_range(40, 7));
            end else begin
                h.data_len = DLEN_W'($urandom_range(6, 0));
            end
            n_body = (h.data_len > MAX_DATA_LEN_DEF) ? MAX_DATA_LEN_DEF : h.data_len;
            if (n_body > 40) begin
                n_sent = $urandom_range(5, 0);
            end else if (n_body > 0 && $urandom_range(99) < 10) begin
                n_sent = $urandom_range(n_body - 1, 0);
            end else begin
                n_sent = n_body;
            end
            send_item(h, PREDICTED, 8'h00, 8'h00);
            repeat (n_sent) send_item(mk_data(rand_line_byte()), PREDICTED, 8'h00, 8'h00);
        end
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (line_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_node_id(input t_cfg_word val);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        node_id = val;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Receiver side: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        int hold_left;
        int hold_seen;
        out_if.ready <= 1'b0;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_asks) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.data;
            if (line_q.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, got %02h last=%0b end=%0b",
                         $time, got.out_byte, got.run_last, got.frame_end);
                fail_cnt++;
            end else begin
                want = line_q.pop_front();
                if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
                    got.frame_end !== want.frame_end) begin
                    $display("%0t: mismatch, expected %02h last=%0b end=%0b, got %02h last=%0b end=%0b",
                             $time, want.out_byte, want.run_last, want.frame_end,
                             got.out_byte, got.run_last, got.frame_end);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        #TIMEOUT_NS;
        $display("pus_packet_hdlc_framer_unit test failed");
        $finish;
    end

    initial begin
        t_row     rows [$];
        t_in_item h;
        int       val;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;
        node_id    = SYS_ID_RESET;
        bytes_left = '0;
        frame_xor  = '0;
        in_frame   = 1'b0;
        foreach (seq_ctr[i]) seq_ctr[i] = '0;

        rows.push_back(mk_row(mk_data(FLAG_BYTE), 0, 8'h00, 8'h00));
        rows.push_back(mk_row(mk_hdr(PKT_TM, 11'd1, 8'hFF, 4'hF, 8'h00, 8'hFF, 14'h3FFF, 12'd0),
                              PREDICTED, 8'h00, 8'h00));
        rows.push_back(mk_row(mk_hdr(PKT_TC, 11'h7FF, 8'd1, 4'hF, FLAG_BYTE, ESC_BYTE, 14'd0,
                                     12'd3), PREDICTED, 8'h00, 8'h00));
        rows.push_back(mk_row(mk_data(FLAG_BYTE), 2, ESC_BYTE, ESC_FLAG));
        rows.push_back(mk_row(mk_data(ESC_BYTE), 2, ESC_BYTE, ESC_ESC));
        rows.push_back(mk_row(mk_data(8'hFF), PREDICTED, 8'h00, 8'h00));
        rows.push_back(mk_row(mk_hdr(PKT_TM, 11'd0, FLAG_BYTE, 4'h0, 8'hFF, 8'h00, 14'h2A7E,
                                     12'hFFF), PREDICTED, 8'h00, 8'h00));
        rows.push_back(mk_row(mk_data(8'h00), 1, 8'h00, 8'h00));
        rows.push_back(mk_row(mk_data(8'hFF), 1, 8'hFF, 8'h00));
        rows.push_back(mk_row(mk_hdr(PKT_TC, 11'h07D, 8'h00, 4'h0, 8'h00, 8'h00, 14'h3FFF,
                                     12'd2), PREDICTED, 8'h00, 8'h00));
        rows.push_back(mk_row(mk_data(FLAG_BYTE), 2, ESC_BYTE, ESC_FLAG));
        rows.push_back(mk_row(mk_data(ESC_FLAG), PREDICTED, 8'h00, 8'h00));
        rows.push_back(mk_row(mk_data(8'h11), 0, 8'h00, 8'h00));
        rows.push_back(mk_row(mk_hdr(PKT_TM, 11'd1, FLAG_BYTE, 4'h5, ESC_BYTE, FLAG_BYTE,
                                     14'h1234, 12'd1), PREDICTED, 8'h00, 8'h00));
        rows.push_back(mk_row(mk_data(FLAG_BYTE), PREDICTED, 8'h00, 8'h00));
        rows.push_back(mk_row(mk_hdr(PKT_TC, 11'd7, 8'd1, 4'hA, 8'h01, 8'h02, 14'h0100,
                                     12'd2048), PREDICTED, 8'h00, 8'h00));
        rows.push_back(mk_row(mk_data(ESC_BYTE), 2, ESC_BYTE, ESC_ESC));
        rows.push_back(mk_row(mk_hdr(PKT_TM, 11'd1, 8'd7, 4'h0, 8'h03, 8'h19, 14'h0000, 12'd0),
                              PREDICTED, 8'h00, 8'h00));

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[i]) send_item(rows[i].item, rows[i].typed_n, rows[i].b0, rows[i].b1);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            tx_idle_pct  = ph_tx[p];
            rx_stall_pct = ph_rx[p];
            if (ph_node[p] == NODE_LOW_RAND) begin
                val = $urandom_range(255);
            end else if (ph_node[p] == NODE_HIGH_RAND) begin
                val = $urandom_range(2046, 256);
            end else begin
                val = ph_node[p];
            end
            write_node_id(t_cfg_word'(val));
            if (ph_press[p]) hold_asks++;
            items_sent = 0;
            while (items_sent < ph_items[p]) begin
                if (ph_wrap[p]) begin
                    // Empty telemetry frames from this node, all on one counter, so it wraps.
                    h = rand_item();
                    h.command      = CMD_HEADER;
                    h.pkt_type     = PKT_TM;
                    h.app_id       = node_id;
                    h.dest_id[2:0] = 3'd5;
                    h.data_len     = '0;
                    send_item(h, PREDICTED, 8'h00, 8'h00);
                end else begin
                    random_frame();
                end
            end
            wait_drained();
        end

        if (fail_cnt == 0 && line_q.size() == 0) begin
            $display("pus_packet_hdlc_framer_unit test passed");
        end else begin
            $display("pus_packet_hdlc_framer_unit test failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/phf_pkg.sv
design/phf_stream_if.sv
design/phf_builder.sv
design/phf_stuffer.sv
design/pus_packet_hdlc_framer_unit.sv
sim/pus_packet_hdlc_framer_unit_tb.sv
